FILE: rtl/idalloc_pkg.sv
// Shared request, response and status types for the id allocator.
`default_nettype none

package idalloc_pkg;

	typedef enum logic {
		OP_ALLOC   = 1'b0,
		OP_RELEASE = 1'b1
	} op_t;

	typedef enum logic [1:0] {
		STAT_GRANTED  = 2'd0,
		STAT_FULL     = 2'd1,
		STAT_RELEASED = 2'd2,
		STAT_IGNORED  = 2'd3
	} status_t;

	typedef struct packed {
		op_t        opcode;
		logic [7:0] release_id;
	} req_t;

	typedef struct packed {
		logic [7:0] slot_id;
		status_t    status;
		logic [8:0] active_count;
	} rsp_t;

endpackage

`default_nettype wire

FILE: rtl/idalloc_ram.sv
// Simple dual-port RAM: one write port, one registered read port.
`default_nettype none

module idalloc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

FILE: rtl/id_allocator_dense_set.sv
// Id allocator top level: free stack, active flags and response register.
//
// Hands out slot ids from a pool of CAPACITY. A request on req (opcode,
// release_id) is taken when req_valid and req_ready are both high. An
// allocate pops the most recently released id, or reports the pool full;
// a release of an active id pushes it back, and a release of an inactive or
// out-of-range id is reported as ignored. Each request gives exactly one
// response on rsp with the id, a status and the active count afterwards.
// Requests pass the input stage, then the response register; one is taken
// every cycle while rsp_ready is high. The free stack sits in a RAM with a
// registered read, so the next stack top is fetched as the request enters,
// with a bypass when the request ahead pushes an id. Ids never yet handed
// out come from a low-water mark, so the stack needs no fill after reset.
// Reset empties both pipeline stages, frees every id and clears all active
// flags. If rsp_ready is low, the response is held and one further request
// is taken into the input stage, after which req_ready drops.
`default_nettype none

module id_allocator_dense_set #(
	parameter int CAPACITY = 256
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              req_valid,
	output logic                   req_ready,
	input  wire idalloc_pkg::req_t req,
	output logic                   rsp_valid,
	input  wire logic              rsp_ready,
	output idalloc_pkg::rsp_t      rsp
);

	localparam int AW    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CW    = $clog2(CAPACITY + 1);
	localparam int RW    = (AW > 8) ? AW : 8;
	localparam int XW    = (CW > 9) ? CW : 9;
	localparam int FLAGS = (CAPACITY < 256) ? CAPACITY : 256;
	localparam int FAW   = $clog2(FLAGS);
	localparam logic [AW-1:0] LAST_ID = AW'(CAPACITY - 1);

	// input stage
	logic                s1_valid_q;
	idalloc_pkg::req_t   req_s1;
	logic                byp_s1;
	logic [AW-1:0]       byp_id_s1;
	// allocator state
	logic [CW-1:0]       free_q;
	logic [CW-1:0]       wm_q;
	logic [FLAGS-1:0]    active_q;
	// response register
	logic                rsp_valid_q;
	idalloc_pkg::rsp_t   rsp_q;

	logic                req_fire;
	logic                s1_fire;
	logic [AW-1:0]       ram_rdata;
	logic [AW-1:0]       top_id;
	logic [RW-1:0]       rid_x;
	logic                in_range;
	logic                flag_hit;
	logic [CW-1:0]       pop_idx;
	logic                fresh;
	logic [AW-1:0]       alloc_id;
	logic                alloc_flagged;
	logic                do_pop;
	logic                do_push;
	logic [CW-1:0]       free_d;
	logic [CW-1:0]       top_idx;
	logic [CW-1:0]       act;
	logic [XW-1:0]       act_x;
	logic [RW-1:0]       slot_x;
	idalloc_pkg::rsp_t   rsp_d;

	assign s1_fire   = s1_valid_q && (!rsp_valid_q || rsp_ready);
	assign req_ready = !s1_valid_q || s1_fire;
	assign req_fire  = req_valid && req_ready;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	always_comb begin
		top_id        = byp_s1 ? byp_id_s1 : ram_rdata;
		rid_x         = RW'(req_s1.release_id);
		in_range      = {1'b0, rid_x} < (RW + 1)'(CAPACITY);
		flag_hit      = in_range && active_q[rid_x[FAW-1:0]];
		pop_idx       = free_q - 1'b1;
		// below the low-water mark the stack still holds its reset order
		fresh         = pop_idx < wm_q;
		alloc_id      = fresh ? (LAST_ID - pop_idx[AW-1:0]) : top_id;
		alloc_flagged = {1'b0, alloc_id} < (AW + 1)'(FLAGS);
		do_pop        = s1_fire && (req_s1.opcode == idalloc_pkg::OP_ALLOC) && (free_q != '0);
		do_push       = s1_fire && (req_s1.opcode == idalloc_pkg::OP_RELEASE) && flag_hit;
		priority if (do_pop) begin
			free_d = free_q - 1'b1;
		end else if (do_push) begin
			free_d = free_q + 1'b1;
		end else begin
			free_d = free_q;
		end
		top_idx = free_d - 1'b1;
		act     = CW'(CAPACITY) - free_d;
		act_x   = XW'(act);
		slot_x  = RW'(alloc_id);
	end

	always_comb begin
		rsp_d.active_count = act_x[8:0];
		unique case (req_s1.opcode)
			idalloc_pkg::OP_ALLOC: begin
				if (free_q == '0) begin
					rsp_d.slot_id = '0;
					rsp_d.status  = idalloc_pkg::STAT_FULL;
				end else begin
					rsp_d.slot_id = slot_x[7:0];
					rsp_d.status  = idalloc_pkg::STAT_GRANTED;
				end
			end
			idalloc_pkg::OP_RELEASE: begin
				rsp_d.slot_id = req_s1.release_id;
				rsp_d.status  = flag_hit ? idalloc_pkg::STAT_RELEASED
				                         : idalloc_pkg::STAT_IGNORED;
			end
			default: begin
				rsp_d.slot_id = '0;
				rsp_d.status  = idalloc_pkg::STAT_IGNORED;
			end
		endcase
	end

	// push writes at the old count, which is also the new top: bypass it
	idalloc_ram #(
		.WIDTH(AW),
		.DEPTH(CAPACITY)
	) u_free_stack (
		.clk  (clk),
		.we   (do_push),
		.waddr(free_q[AW-1:0]),
		.wdata(rid_x[AW-1:0]),
		.re   (req_fire),
		.raddr(top_idx[AW-1:0]),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q  <= 1'b0;
			rsp_valid_q <= 1'b0;
			free_q      <= CW'(CAPACITY);
			wm_q        <= CW'(CAPACITY);
			active_q    <= '0;
		end else begin
			if (req_fire) begin
				s1_valid_q <= 1'b1;
			end else if (s1_fire) begin
				s1_valid_q <= 1'b0;
			end
			if (s1_fire) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
			free_q <= free_d;
			if (do_pop && fresh) begin
				wm_q <= pop_idx;
			end
			if (do_pop && alloc_flagged) begin
				active_q[alloc_id[FAW-1:0]] <= 1'b1;
			end
			if (do_push) begin
				active_q[rid_x[FAW-1:0]] <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req_fire) begin
			req_s1    <= req;
			byp_s1    <= do_push;
			byp_id_s1 <= rid_x[AW-1:0];
		end
		if (s1_fire) begin
			rsp_q <= rsp_d;
		end
	end

endmodule

`default_nettype wire

FILE: tb/id_allocator_dense_set_test.sv
// Self-checking bench for the id allocator: request driver, response checker and watchdog.
`timescale 1ns / 100ps

module id_allocator_dense_set_test;

	localparam int RANDOM_ITEMS   = 1800;
	localparam int CALM_ITEMS     = 150;
	localparam int SQUEEZE_AT     = 600;
	localparam int SQUEEZE_CYCLES = 300;
	localparam int STUCK_LIMIT    = 4000;

	typedef enum int {
		MIX_FILL,
		MIX_DRAIN,
		MIX_BLEND
	} mix_t;

	typedef struct {
		idalloc_pkg::req_t req;
		idalloc_pkg::rsp_t rsp;
	} pend_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_ready;
	idalloc_pkg::req_t req = '0;
	logic rsp_valid;
	logic rsp_ready = 1'b0;
	idalloc_pkg::rsp_t rsp;

	id_allocator_dense_set uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	// Allocator state as seen by the predictor
	logic [7:0] stack_ids [256];
	logic [8:0] stack_depth;
	logic [7:0] members [256];
	logic [8:0] member_cnt;
	logic [7:0] member_pos [256];
	logic       in_use [256];

	pend_t             pending [$];
	idalloc_pkg::rsp_t awaited [$];
	idalloc_pkg::rsp_t on_bus_rsp;
	int    total_items = 0;
	int    errors = 0;
	logic [7:0] last_freed = 8'd0;

	function automatic idalloc_pkg::rsp_t allocate_or_release(idalloc_pkg::req_t r);
		idalloc_pkg::rsp_t o;
		logic [7:0] id;
		logic [7:0] pos;
		logic [7:0] tail_id;
		o.slot_id = 8'd0;
		if (r.opcode == idalloc_pkg::OP_ALLOC) begin
			if (stack_depth == 9'd0) begin
				o.status = idalloc_pkg::STAT_FULL;
			end else begin
				stack_depth = stack_depth - 9'd1;
				id = stack_ids[stack_depth[7:0]];
				in_use[id] = 1'b1;
				member_pos[id] = member_cnt[7:0];
				members[member_cnt[7:0]] = id;
				member_cnt = member_cnt + 9'd1;
				o.slot_id = id;
				o.status = idalloc_pkg::STAT_GRANTED;
			end
		end else begin
			o.slot_id = r.release_id;
			if (!in_use[r.release_id]) begin
				o.status = idalloc_pkg::STAT_IGNORED;
			end else begin
				// swap the last member into the freed position
				pos = member_pos[r.release_id];
				tail_id = members[member_cnt[7:0] - 8'd1];
				in_use[r.release_id] = 1'b0;
				members[pos] = tail_id;
				member_pos[tail_id] = pos;
				member_cnt = member_cnt - 9'd1;
				stack_ids[stack_depth[7:0]] = r.release_id;
				stack_depth = stack_depth + 9'd1;
				o.status = idalloc_pkg::STAT_RELEASED;
			end
		end
		o.active_count = member_cnt;
		return o;
	endfunction

	task automatic queue_request(idalloc_pkg::op_t op, logic [7:0] id);
		pend_t p;
		p.req.opcode = op;
		p.req.release_id = id;
		p.rsp = allocate_or_release(p.req);
		if (p.rsp.status == idalloc_pkg::STAT_RELEASED)
			last_freed = id;
		pending.insert(pending.size(), p);
	endtask

	task automatic queue_release_of_member();
		if (member_cnt == 9'd0)
			queue_request(idalloc_pkg::OP_RELEASE, 8'($urandom_range(0, 255)));
		else
			queue_request(idalloc_pkg::OP_RELEASE, members[$urandom_range(0, member_cnt - 1)]);
	endtask

	// Noise: a release of any id, or a second release of the id freed last
	task automatic queue_stray_release();
		if ($urandom_range(0, 1) == 0)
			queue_request(idalloc_pkg::OP_RELEASE, 8'($urandom_range(0, 255)));
		else
			queue_request(idalloc_pkg::OP_RELEASE, last_freed);
	endtask

	// Request driver
	logic send_idle_on = 1'b1;
	int   send_gap = 0;
	int   sent_cnt = 0;

	always @(posedge clk or negedge arst_n) begin
		pend_t nxt;
		if (!arst_n) begin
			req_valid <= 1'b0;
			req <= '0;
			send_gap = 0;
		end else begin
			if (req_valid && req_ready) begin
				awaited.insert(awaited.size(), on_bus_rsp);
				sent_cnt++;
				if (sent_cnt % 64 == 0)
					send_idle_on = $urandom_range(0, 2) != 0;
			end
			if (!req_valid || req_ready) begin
				if (send_gap != 0) begin
					send_gap--;
					req_valid <= 1'b0;
				end else if (pending.size() == 0) begin
					req_valid <= 1'b0;
				end else if (send_idle_on && pending.size() > CALM_ITEMS &&
						$urandom_range(0, 5) == 0) begin
					send_gap = $urandom_range(0, 15);
					req_valid <= 1'b0;
				end else begin
					nxt = pending.pop_front();
					on_bus_rsp = nxt.rsp;
					req <= nxt.req;
					req_valid <= 1'b1;
				end
			end
		end
	end

	// Response checker and receiver stalls
	logic recv_idle_on = 1'b1;
	logic squeeze_done = 1'b0;
	int   recv_gap = 0;
	int   recv_cnt = 0;

	always @(posedge clk or negedge arst_n) begin
		idalloc_pkg::rsp_t want;
		if (!arst_n) begin
			rsp_ready <= 1'b0;
			recv_gap = 0;
		end else begin
			if (rsp_valid && rsp_ready) begin
				recv_cnt++;
				if (recv_cnt % 64 == 0)
					recv_idle_on = $urandom_range(0, 2) != 0;
				if (awaited.size() == 0) begin
					errors++;
					$display("%0t: response with none outstanding: slot_id %0d status %0d count %0d",
						$time, rsp.slot_id, rsp.status, rsp.active_count);
				end else begin
					want = awaited.pop_front();
					if (rsp.slot_id !== want.slot_id) begin
						errors++;
						$display("%0t: slot_id expected %0d, got %0d",
							$time, want.slot_id, rsp.slot_id);
					end
					if (rsp.status !== want.status) begin
						errors++;
						$display("%0t: status expected %s, got %0d",
							$time, want.status.name(), rsp.status);
					end
					if (rsp.active_count !== want.active_count) begin
						errors++;
						$display("%0t: active_count expected %0d, got %0d",
							$time, want.active_count, rsp.active_count);
					end
				end
			end
			if (recv_gap != 0) begin
				recv_gap--;
				rsp_ready <= 1'b0;
			end else if (!squeeze_done && recv_cnt >= SQUEEZE_AT) begin
				// hold off long enough for the block to back up onto the request side
				squeeze_done = 1'b1;
				recv_gap = SQUEEZE_CYCLES - 1;
				rsp_ready <= 1'b0;
			end else if (recv_idle_on && recv_cnt + CALM_ITEMS < total_items &&
					$urandom_range(0, 5) == 0) begin
				recv_gap = $urandom_range(0, 15);
				rsp_ready <= 1'b0;
			end else begin
				rsp_ready <= 1'b1;
			end
		end
	end

	int stuck = 0;

	always @(posedge clk) begin
		if (arst_n) begin
			if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
				stuck = 0;
			else
				stuck++;
			if (stuck == STUCK_LIMIT) begin
				$display("%0t: no progress for %0d cycles", $time, STUCK_LIMIT);
				$display("simulation failed");
				$finish;
			end
		end
	end

	initial begin
		mix_t mix;
		int   span;
		int   roll;
		int   phase;
		for (int k = 0; k < 256; k++) begin
			stack_ids[k] = 8'(255 - k);
			members[k] = 8'd0;
			member_pos[k] = 8'd0;
			in_use[k] = 1'b0;
		end
		stack_depth = 9'd256;
		member_cnt = 9'd0;

		// Directed: ascending grants, releases at either end and in the middle,
		// double and stray releases, LIFO reuse, empty pool
		queue_request(idalloc_pkg::OP_ALLOC, 8'd0);
		queue_request(idalloc_pkg::OP_ALLOC, 8'd255);
		queue_request(idalloc_pkg::OP_ALLOC, 8'h5a);
		queue_request(idalloc_pkg::OP_ALLOC, 8'ha5);
		queue_request(idalloc_pkg::OP_RELEASE, 8'd255);
		queue_request(idalloc_pkg::OP_RELEASE, 8'd1);
		queue_request(idalloc_pkg::OP_RELEASE, 8'd1);
		queue_request(idalloc_pkg::OP_ALLOC, 8'd0);
		queue_request(idalloc_pkg::OP_RELEASE, 8'd0);
		queue_request(idalloc_pkg::OP_RELEASE, 8'd1);
		queue_request(idalloc_pkg::OP_RELEASE, 8'd0);
		queue_request(idalloc_pkg::OP_ALLOC, 8'd255);
		queue_request(idalloc_pkg::OP_ALLOC, 8'd0);
		queue_request(idalloc_pkg::OP_ALLOC, 8'd128);
		queue_request(idalloc_pkg::OP_RELEASE, 8'd2);
		queue_request(idalloc_pkg::OP_RELEASE, 8'd3);
		queue_request(idalloc_pkg::OP_RELEASE, 8'd4);
		queue_request(idalloc_pkg::OP_RELEASE, 8'd0);
		queue_request(idalloc_pkg::OP_RELEASE, 8'd1);
		queue_request(idalloc_pkg::OP_RELEASE, 8'd128);
		queue_request(idalloc_pkg::OP_ALLOC, 8'd255);

		// Random: fill to the top first so the pool-full path is reached early
		phase = 0;
		while (pending.size() < RANDOM_ITEMS) begin
			mix = (phase == 0) ? MIX_FILL : mix_t'($urandom_range(0, 2));
			span = (phase == 0) ? 400 : $urandom_range(30, 300);
			for (int k = 0; k < span && pending.size() < RANDOM_ITEMS; k++) begin
				roll = $urandom_range(0, 99);
				case (mix)
					MIX_FILL: begin
						if (roll < 90)
							queue_request(idalloc_pkg::OP_ALLOC, 8'($urandom_range(0, 255)));
						else if (roll < 97)
							queue_release_of_member();
						else
							queue_stray_release();
					end
					MIX_DRAIN: begin
						if (roll < 85)
							queue_release_of_member();
						else if (roll < 95)
							queue_request(idalloc_pkg::OP_ALLOC, 8'($urandom_range(0, 255)));
						else
							queue_stray_release();
					end
					default: begin
						if (roll < 50)
							queue_request(idalloc_pkg::OP_ALLOC, 8'($urandom_range(0, 255)));
						else if (roll < 90)
							queue_release_of_member();
						else
							queue_stray_release();
					end
				endcase
			end
			phase++;
		end
		total_items = pending.size();

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		do
			@(posedge clk);
		while (pending.size() != 0 || req_valid || awaited.size() != 0);
		repeat (8) @(posedge clk);

		if (errors == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
